### design/compass_heading_atan2_top_assert.svh
// Assertion macros used by the compass heading top level.
`ifndef COMPASS_HEADING_ATAN2_TOP_ASSERT_SVH
`define COMPASS_HEADING_ATAN2_TOP_ASSERT_SVH

// Same-cycle implication, checked while reset is released.
`define CHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define CHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/cha_pkg.sv
// Package with types, constants and the arctangent table of the compass heading block.
package cha_pkg;

    localparam int unsigned CHA_BYTE_W       = 8;
    localparam int unsigned CHA_AXIS_W       = 16;
    localparam int unsigned CHA_HEAD_W       = 16;
    localparam int unsigned CHA_TABLE_LEN    = 24;
    localparam int unsigned CHA_ITER_DEFAULT = 16;
    localparam int unsigned CHA_PRESCALE     = 14;
    localparam int unsigned CHA_Q_DEPTH      = 2;

    // Datapath widths: rotated vector, angle accumulator, clamped angle, rounded sum.
    localparam int unsigned CHA_XW    = 32;
    localparam int unsigned CHA_ZW    = 24;
    localparam int unsigned CHA_AW    = 22;
    localparam int unsigned CHA_FINE_W = 24;

    // Angles in units of 2^-15 degree.
    localparam int unsigned CHA_DEG90_FINE  = 2949120;
    localparam int unsigned CHA_DEG180_FINE = 5898240;
    localparam int unsigned CHA_DEG360_FINE = 11796480;
    localparam int unsigned CHA_ROUND       = 128;
    localparam int unsigned CHA_OUT_SHIFT   = 8;
    localparam int unsigned CHA_HEAD_MAX    = 46080;

    // One classified sample as it travels from the front end to the back end.
    typedef struct packed {
        logic [CHA_AXIS_W-1:0] ax;
        logic [CHA_AXIS_W-1:0] ay;
        logic                  xneg;
        logic                  yneg;
        logic                  xzero;
        logic                  yzero;
    } t_item;

    // Quadrant and special-case flags carried down the rotation pipeline.
    typedef struct packed {
        logic xneg;
        logic yneg;
        logic xzero;
        logic yzero;
    } t_flags;

    // atan(2^-i) in units of 2^-15 degree, rounded.
    function automatic logic signed [CHA_ZW-1:0] cha_atan(input int unsigned idx);
        logic signed [CHA_ZW-1:0] v;
        case (idx)
            0:       v = 24'sd1474560;
            1:       v = 24'sd870484;
            2:       v = 24'sd459940;
            3:       v = 24'sd233473;
            4:       v = 24'sd117189;
            5:       v = 24'sd58652;
            6:       v = 24'sd29333;
            7:       v = 24'sd14667;
            8:       v = 24'sd7334;
            9:       v = 24'sd3667;
            10:      v = 24'sd1833;
            11:      v = 24'sd917;
            12:      v = 24'sd458;
            13:      v = 24'sd229;
            14:      v = 24'sd115;
            15:      v = 24'sd57;
            16:      v = 24'sd29;
            17:      v = 24'sd14;
            18:      v = 24'sd7;
            19:      v = 24'sd4;
            20:      v = 24'sd2;
            21:      v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### design/cha_front.sv
// Front end: takes a sample transaction, joins the bytes and classifies the axes.
module cha_front (
    input  logic                          start,
    input  logic                          i_full,
    input  logic [cha_pkg::CHA_BYTE_W-1:0] i_x_high,
    input  logic [cha_pkg::CHA_BYTE_W-1:0] i_x_low,
    input  logic [cha_pkg::CHA_BYTE_W-1:0] i_y_high,
    input  logic [cha_pkg::CHA_BYTE_W-1:0] i_y_low,
    output logic                          o_push,
    output cha_pkg::t_item                o_item
);
    import cha_pkg::*;

    logic signed [CHA_AXIS_W-1:0] x;
    logic signed [CHA_AXIS_W-1:0] y;

    // Joining the bytes as two's complement is the same as subtracting 65536 above 0x7fff.
    assign x = $signed({i_x_high, i_x_low});
    assign y = $signed({i_y_high, i_y_low});

    assign o_push = start && !i_full;

    always_comb begin
        o_item.xneg  = x[CHA_AXIS_W-1];
        o_item.yneg  = y[CHA_AXIS_W-1];
        // The magnitude of the most negative sample wraps to 0x8000, read unsigned.
        o_item.ax    = x[CHA_AXIS_W-1] ? CHA_AXIS_W'(-x) : CHA_AXIS_W'(x);
        o_item.ay    = y[CHA_AXIS_W-1] ? CHA_AXIS_W'(-y) : CHA_AXIS_W'(y);
        o_item.xzero = (x == '0);
        o_item.yzero = (y == '0);
    end

endmodule

### design/cha_queue.sv
// Short queue between the front end and the rotation back end.
module cha_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cha_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output cha_pkg::t_item o_item
);
    import cha_pkg::*;

    localparam int unsigned PTR_W = (CHA_Q_DEPTH > 1) ? $clog2(CHA_Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(CHA_Q_DEPTH + 1);

    t_item             r_mem [CHA_Q_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr;
    logic [PTR_W-1:0]  n_rd;
    logic [CNT_W-1:0]  n_count;
    logic              pop;

    assign o_full  = (r_count == CNT_W'(CHA_Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(CHA_Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(CHA_Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

### design/cha_back.sv
// Back end: pipelined vectoring rotations, quadrant fold and rounding of the heading.
module cha_back #(
    parameter int unsigned ITERS = cha_pkg::CHA_ITER_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  cha_pkg::t_item                i_item,
    output logic                          o_done,
    output logic [cha_pkg::CHA_HEAD_W-1:0] o_heading
);
    import cha_pkg::*;

    // Rotations stop at the end of the arctangent table.
    localparam int unsigned STAGES = (ITERS < CHA_TABLE_LEN) ? ITERS : CHA_TABLE_LEN;

    logic signed [CHA_XW-1:0] r_x  [STAGES+1];
    logic signed [CHA_XW-1:0] r_y  [STAGES+1];
    logic signed [CHA_ZW-1:0] r_z  [STAGES+1];
    t_flags                   r_fl [STAGES+1];
    logic                     r_v  [STAGES+1];

    logic [CHA_AW-1:0]     r_a;
    t_flags                r_a_fl;
    logic                  r_a_v;
    logic [CHA_AW-1:0]     n_a;
    logic [CHA_FINE_W-1:0] n_sum;
    logic [CHA_FINE_W-1:0] a_ext;

    // Entry stage: scale the magnitudes up before rotating.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_x[0]  <= $signed({{(CHA_XW - CHA_AXIS_W - CHA_PRESCALE){1'b0}}, i_item.ax,
                            {CHA_PRESCALE{1'b0}}});
        r_y[0]  <= $signed({{(CHA_XW - CHA_AXIS_W - CHA_PRESCALE){1'b0}}, i_item.ay,
                            {CHA_PRESCALE{1'b0}}});
        r_z[0]  <= '0;
        r_fl[0] <= '{xneg: i_item.xneg, yneg: i_item.yneg,
                     xzero: i_item.xzero, yzero: i_item.yzero};
    end

    // One micro-rotation per stage; the shifts round toward minus infinity.
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            if (!r_y[k][CHA_XW-1]) begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + cha_atan(k);
            end else begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - cha_atan(k);
            end
            r_fl[k+1] <= r_fl[k];
        end
    end

    // First-quadrant angle with the axis cases forced exact and the sum clamped to 0..90.
    always_comb begin
        if (r_fl[STAGES].yzero) begin
            n_a = '0;
        end else if (r_fl[STAGES].xzero) begin
            n_a = CHA_AW'(CHA_DEG90_FINE);
        end else if (r_z[STAGES][CHA_ZW-1]) begin
            n_a = '0;
        end else if (r_z[STAGES][CHA_ZW-2:0] > (CHA_ZW-1)'(CHA_DEG90_FINE)) begin
            n_a = CHA_AW'(CHA_DEG90_FINE);
        end else begin
            n_a = r_z[STAGES][CHA_AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= r_v[STAGES];
        end
        r_a    <= n_a;
        r_a_fl <= r_fl[STAGES];
    end

    // Quadrant fold, 180 degree offset and half-up rounding fall into one add.
    assign a_ext = CHA_FINE_W'(r_a);

    always_comb begin
        if (!r_a_fl.xneg && !r_a_fl.yneg) begin
            n_sum = CHA_FINE_W'(CHA_DEG180_FINE + CHA_ROUND) + a_ext;
        end else if (r_a_fl.xneg && !r_a_fl.yneg) begin
            n_sum = CHA_FINE_W'(CHA_DEG360_FINE + CHA_ROUND) - a_ext;
        end else if (!r_a_fl.xneg && r_a_fl.yneg) begin
            n_sum = CHA_FINE_W'(CHA_DEG180_FINE + CHA_ROUND) - a_ext;
        end else begin
            n_sum = CHA_FINE_W'(CHA_ROUND) + a_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_a_v;
        end
        o_heading <= n_sum[CHA_OUT_SHIFT +: CHA_HEAD_W];
    end

endmodule

### design/compass_heading_atan2_top.sv
// Top level of the compass heading block: front end, queue and rotation back end.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+--------------------------------------
//  sample   | in        | start high, busy low    | i_x_high, i_x_low, i_y_high, i_y_low
//  heading  | out       | o_done strobe, 1 cycle  | o_heading (1/128 degree, 0..46080)
//
// A sample transaction may be accepted in every cycle, and one heading leaves per
// cycle. The heading of a sample is on the result ports after the registers below and
// is taken at the following edge. The registers on the way are the queue write at the
// accepting edge, one entry stage, one stage per rotation (up to 24), one clamp stage
// and one output register. The rotation pipeline sets the length of that path. Reset
// is synchronous and active low; it empties the queue and clears every stage valid, so
// no strobe follows reset until a new sample enters. The receiver cannot stall, so the
// back end drains the queue every cycle and busy rises only if the queue were full.
module compass_heading_atan2_top #(
    parameter int unsigned ANGLE_ITERATIONS = cha_pkg::CHA_ITER_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cha_pkg::CHA_BYTE_W-1:0] i_x_high,
    input  logic [cha_pkg::CHA_BYTE_W-1:0] i_x_low,
    input  logic [cha_pkg::CHA_BYTE_W-1:0] i_y_high,
    input  logic [cha_pkg::CHA_BYTE_W-1:0] i_y_low,
    output logic                          o_done,
    output logic [cha_pkg::CHA_HEAD_W-1:0] o_heading
);
    import cha_pkg::*;

`include "compass_heading_atan2_top_assert.svh"

    logic  q_push;
    logic  q_full;
    logic  q_valid;
    t_item f_item;
    t_item q_item;

    // The front end only pushes when the queue has room; busy is that same full flag.
    cha_front u_front (
        .start    (start),
        .i_full   (q_full),
        .i_x_high (i_x_high),
        .i_x_low  (i_x_low),
        .i_y_high (i_y_high),
        .i_y_low  (i_y_low),
        .o_push   (q_push),
        .o_item   (f_item)
    );

    cha_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .i_pop   (q_valid),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // The back end never stalls, so every queued sample is popped the cycle it shows.
    cha_back #(
        .ITERS (ANGLE_ITERATIONS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_item    (q_item),
        .o_done    (o_done),
        .o_heading (o_heading)
    );

    assign busy = q_full;

    // A heading never leaves the range 0 to 360 degrees.
    `CHA_ASSERT_IMPL(a_heading_range, i_clk, i_rst_n, o_done,
        o_heading <= CHA_HEAD_W'(CHA_HEAD_MAX), "heading above 360 degrees")
    // An accepted sample is waiting in the queue on the next cycle.
    `CHA_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, start && !busy, q_valid,
        "accepted sample missing from the queue")
    // A pop without a push leaves room, so busy cannot follow it.
    `CHA_ASSERT_NEXT(a_pop_frees, i_clk, i_rst_n, q_valid && !q_push, !busy,
        "queue full right after a pop")

endmodule
